// ===== sv/ptrm_pkg.sv =====
// ----------------------------------------------------------------------------
// ptrm_pkg
// Shared constants, types and reset values for the periodic task release
// monitor and its task cells.
// ----------------------------------------------------------------------------
package ptrm_pkg;

  // Number of periodic tasks, one cell each (1 to 3).
  localparam int NUM_TASKS = 3;

  // Fixed field widths.
  localparam int TASK_W     = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_W      = 48;
  localparam int HOR_W      = 16;
  localparam int IN_DATA_W  = 8;
  localparam int OUT_DATA_W = 296;

  // Input opcodes, carried on tuser.
  localparam logic OP_TICK = 1'b0;
  localparam logic OP_READ = 1'b1;

  // Result kinds, carried on tuser.
  localparam logic KIND_RUN    = 1'b0;
  localparam logic KIND_REPORT = 1'b1;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_TASK0   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TASK1   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TASK2   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_HORIZON = 2'd3;

  localparam logic [HOR_W-1:0] HORIZON_RESET = 16'd1000;

  // Token and virtual time handed from one cell to the next.
  typedef struct packed {
    logic        tok;
    logic [31:0] vt;
  } link_t;

  // One run record as produced by a cell.
  typedef struct packed {
    logic [15:0]        rel_ms;
    logic [31:0]        start_ms;
    logic [31:0]        done_ms;
    logic               deadline_missed;
    logic signed [31:0] start_error;
    logic [31:0]        run_total;
    logic [31:0]        missed_count;
    logic signed [47:0] error_sum;
    logic [63:0]        error_sq_sum;
  } rec_t;

  // Counters of one task as seen by a report.
  typedef struct packed {
    logic [15:0]        next_release;
    logic [31:0]        run_count;
    logic [31:0]        miss_count;
    logic signed [47:0] err_sum;
    logic [63:0]        err_sq_sum;
  } cnt_t;

  // Timing register reset values: duration, deadline, period in ms.
  function automatic logic [CFG_W-1:0] timing_reset(input logic [CFG_IDX_W-1:0] idx);
    logic [CFG_W-1:0] val;
    begin
      case (idx)
        REG_TASK0: val = {16'd1, 16'd5, 16'd10};
        REG_TASK1: val = {16'd2, 16'd12, 16'd25};
        REG_TASK2: val = {16'd3, 16'd25, 16'd50};
        default:   val = '0;
      endcase
      return val;
    end
  endfunction

endpackage

// ===== sv/periodic_task_release_monitor_unit.sv =====
// ----------------------------------------------------------------------------
// periodic_task_release_monitor_unit
// Cyclic executive monitor for fixed-priority periodic tasks with per-run
// deadline check, start-error statistics and counter reports.
// ----------------------------------------------------------------------------
// The block takes one transaction at a time on the slave side: tuser selects
// a millisecond tick or a counter read. A tick advances time and sends a
// token down a row of task cells, highest priority first; each cell whose
// release is due and below the horizon runs its task, emits one run record
// and hands the completion time on as the start of the next run. A cell that
// is not due passes the token on; a cell that runs takes the token and then
// works through the five steps of the cell: grid multiply, error clamp,
// saturating sum, squaring multiply and commit. A read posts its report once
// the output register is free. Each record waits in a single output register,
// and a cell holds at its commit step while that register is full, so a
// stalled master side lengthens the tick by the stall. The final record of a
// transaction carries tlast; a tick on which no task is due produces no
// record. Configuration writes are accepted at any cycle and are meant to be
// made while idle.
// ----------------------------------------------------------------------------
module periodic_task_release_monitor_unit (
  input  logic                                clk,
  input  logic                                rst,
  // Configuration write port.
  input  logic                                cfg_we,
  input  logic [ptrm_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [ptrm_pkg::CFG_W-1:0]          cfg_data,
  // Input stream.
  input  logic                                s_tvalid,
  output logic                                s_tready,
  input  logic [ptrm_pkg::IN_DATA_W-1:0]      s_tdata,  // task_sel[1:0], zero pad
  input  logic [0:0]                          s_tuser,  // opcode[0]
  // Output stream.
  output logic                                m_tvalid,
  input  logic                                m_tready,
  // task_id[1:0], release[17:2], start[49:18], completion[81:50],
  // deadline_missed[82], start_error[114:83], run total[146:115],
  // missed_count[178:147], error_sum[226:179], error_sq_sum[290:227], zero pad
  output logic [ptrm_pkg::OUT_DATA_W-1:0]     m_tdata,
  output logic [0:0]                          m_tuser,  // kind[0]
  output logic                                m_tlast
);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_RUN    = 2'd1;
  localparam logic [1:0] ST_REPORT = 2'd2;

  localparam int PAD_W = ptrm_pkg::OUT_DATA_W - 291;

  logic [ptrm_pkg::CFG_W-1:0] timing [ptrm_pkg::NUM_TASKS];
  logic [ptrm_pkg::HOR_W-1:0] horizon;

  logic [1:0]                  state;
  logic [31:0]                 now_tick;
  logic [ptrm_pkg::TASK_W-1:0] sel;
  logic                        start_tok;

  logic in_accept;
  logic tick_accept;
  logic out_free;

  ptrm_pkg::link_t chain [ptrm_pkg::NUM_TASKS+1];
  ptrm_pkg::rec_t  rec_arr [ptrm_pkg::NUM_TASKS];
  ptrm_pkg::cnt_t  cnt_arr [ptrm_pkg::NUM_TASKS];
  logic [ptrm_pkg::NUM_TASKS-1:0] due_vec;
  logic [ptrm_pkg::NUM_TASKS-1:0] rec_vld;
  logic [ptrm_pkg::NUM_TASKS-1:0] last_vec;
  logic [ptrm_pkg::NUM_TASKS-1:0] rec_last_vec;
  logic [ptrm_pkg::NUM_TASKS:0]   tok_vec;

  // Selected run record from the row of cells.
  ptrm_pkg::rec_t              run_rec;
  logic [ptrm_pkg::TASK_W-1:0] run_id;
  logic                        run_last;
  logic                        run_any;

  // Selected counters for a report.
  ptrm_pkg::cnt_t rep_cnt;
  logic           rep_ok;

  logic later_due;

  assign s_tready    = (state == ST_IDLE);
  assign in_accept   = s_tvalid && s_tready;
  assign tick_accept = in_accept && (s_tuser[0] == ptrm_pkg::OP_TICK);
  assign out_free    = !m_tvalid || m_tready;

  // Configuration registers. Writes to an index without a register are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      horizon <= ptrm_pkg::HORIZON_RESET;
      for (int i = 0; i < ptrm_pkg::NUM_TASKS; i++) begin
        timing[i] <= (i < int'(ptrm_pkg::REG_HORIZON)) ?
                     ptrm_pkg::timing_reset(ptrm_pkg::CFG_IDX_W'(i)) : '0;
      end
    end else if (cfg_we) begin
      if (cfg_index == ptrm_pkg::REG_HORIZON) begin
        horizon <= cfg_data[ptrm_pkg::HOR_W-1:0];
      end else begin
        for (int i = 0; i < ptrm_pkg::NUM_TASKS; i++) begin
          if ((i < int'(ptrm_pkg::REG_HORIZON)) &&
              (cfg_index == ptrm_pkg::CFG_IDX_W'(i))) begin
            timing[i] <= cfg_data;
          end
        end
      end
    end
  end

  // Sequencer: start the token for a tick, or wait to post a report.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      now_tick  <= '0;
      start_tok <= 1'b0;
    end else begin
      start_tok <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (in_accept) begin
            if (s_tuser[0] == ptrm_pkg::OP_READ) begin
              sel   <= s_tdata[ptrm_pkg::TASK_W-1:0];
              state <= ST_REPORT;
            end else begin
              now_tick  <= now_tick + 32'd1;
              start_tok <= 1'b1;
              state     <= ST_RUN;
            end
          end
        end
        ST_RUN: begin
          if (chain[ptrm_pkg::NUM_TASKS].tok) begin
            state <= ST_IDLE;
          end
        end
        ST_REPORT: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  assign chain[0].tok = start_tok;
  assign chain[0].vt  = now_tick;

  // A run is the last record of its tick when no lower-priority task is due.
  always_comb begin
    later_due = 1'b0;
    for (int i = ptrm_pkg::NUM_TASKS - 1; i >= 0; i--) begin
      last_vec[i] = ~later_due;
      later_due   = later_due | due_vec[i];
    end
  end

  for (genvar g = 0; g < ptrm_pkg::NUM_TASKS; g++) begin : g_cell
    ptrm_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .timing    (timing[g]),
      .horizon   (horizon),
      .now_eval  (now_tick + 32'd1),
      .eval      (tick_accept),
      .link_in   (chain[g]),
      .is_last   (last_vec[g]),
      .out_free  (out_free),
      .link_out  (chain[g+1]),
      .due       (due_vec[g]),
      .rec_valid (rec_vld[g]),
      .rec_last  (rec_last_vec[g]),
      .rec       (rec_arr[g]),
      .cnt       (cnt_arr[g])
    );
  end

  always_comb begin
    for (int i = 0; i <= ptrm_pkg::NUM_TASKS; i++) begin
      tok_vec[i] = chain[i].tok;
    end
  end

  // Only one cell sits at its commit step at a time.
  always_comb begin
    run_rec  = rec_arr[0];
    run_id   = '0;
    run_last = 1'b0;
    run_any  = 1'b0;
    for (int i = 0; i < ptrm_pkg::NUM_TASKS; i++) begin
      if (rec_vld[i]) begin
        run_rec  = rec_arr[i];
        run_id   = ptrm_pkg::TASK_W'(i);
        run_last = rec_last_vec[i];
        run_any  = 1'b1;
      end
    end
  end

  // Counters of the selected task; an out-of-range selection reports zeros.
  always_comb begin
    rep_cnt = '0;
    rep_ok  = 1'b0;
    for (int i = 0; i < ptrm_pkg::NUM_TASKS; i++) begin
      if (sel == ptrm_pkg::TASK_W'(i)) begin
        rep_cnt = cnt_arr[i];
        rep_ok  = 1'b1;
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      if (out_free && run_any) begin
        m_tvalid   <= 1'b1;
        m_tuser[0] <= ptrm_pkg::KIND_RUN;
        m_tlast    <= run_last;
        m_tdata    <= {{PAD_W{1'b0}}, run_rec.error_sq_sum, run_rec.error_sum,
                       run_rec.missed_count, run_rec.run_total, run_rec.start_error,
                       run_rec.deadline_missed, run_rec.done_ms,
                       run_rec.start_ms, run_rec.rel_ms, run_id};
      end else if (out_free && (state == ST_REPORT)) begin
        m_tvalid   <= 1'b1;
        m_tuser[0] <= ptrm_pkg::KIND_REPORT;
        m_tlast    <= 1'b1;
        m_tdata    <= {{PAD_W{1'b0}}, rep_cnt.err_sq_sum, rep_cnt.err_sum,
                       rep_cnt.miss_count, rep_cnt.run_count, 32'b0, 1'b0, 32'b0,
                       (rep_ok ? now_tick : 32'b0), rep_cnt.next_release, sel};
      end
    end
  end

  // At most one cell holds the token, and at most one offers a record.
  a_one_token: assert property (@(posedge clk) disable iff (rst)
    $onehot0(tok_vec))
    else $error("token held by more than one cell");

  a_one_record: assert property (@(posedge clk) disable iff (rst)
    $onehot0(rec_vld))
    else $error("more than one cell offers a run record");

  a_idle_quiet: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE) |-> (rec_vld == '0))
    else $error("run record offered while the sequencer is idle");

  a_tick_time: assert property (@(posedge clk) disable iff (rst)
    tick_accept |=> (now_tick == $past(now_tick) + 32'd1))
    else $error("accepted tick did not advance time by one");

  a_report_post: assert property (@(posedge clk) disable iff (rst)
    ((state == ST_REPORT) && out_free) |=>
      (m_tvalid && (m_tuser[0] == ptrm_pkg::KIND_REPORT) && m_tlast))
    else $error("counter report not posted when the output was free");

endmodule

// ===== sv/ptrm_cell.sv =====
// ----------------------------------------------------------------------------
// ptrm_cell
// One task of the executive: holds the task's release and statistics, runs
// the grid, error, sum and square steps when the token reaches it, and hands
// the token with the updated virtual time to the next cell.
// ----------------------------------------------------------------------------
module ptrm_cell (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [ptrm_pkg::CFG_W-1:0]    timing,
  input  logic [ptrm_pkg::HOR_W-1:0]    horizon,
  input  logic [31:0]                   now_eval,
  input  logic                          eval,
  input  ptrm_pkg::link_t               link_in,
  input  logic                          is_last,
  input  logic                          out_free,
  output ptrm_pkg::link_t               link_out,
  output logic                          due,
  output logic                          rec_valid,
  output logic                          rec_last,
  output ptrm_pkg::rec_t                rec,
  output ptrm_pkg::cnt_t                cnt
);

  localparam logic [2:0] PH_GRID   = 3'd0;
  localparam logic [2:0] PH_ERR    = 3'd1;
  localparam logic [2:0] PH_SUM    = 3'd2;
  localparam logic [2:0] PH_SQ     = 3'd3;
  localparam logic [2:0] PH_COMMIT = 3'd4;

  logic [15:0] period;
  logic [15:0] deadline;
  logic [15:0] duration;

  // Task state.
  logic [15:0]        next_release;
  logic [31:0]        run_count;
  logic [31:0]        miss_count;
  logic signed [47:0] err_sum;
  logic [63:0]        err_sq_sum;

  // Control.
  logic       busy;
  logic [2:0] phase;
  logic       tok_out;
  logic [31:0] vt_out;

  // Datapath registers of the current run.
  logic [31:0]        vt;
  logic [31:0]        ideal;
  logic [31:0]        done;
  logic               missed;
  logic signed [31:0] err;
  logic [31:0]        mag;
  logic signed [47:0] sum_new;
  logic [63:0]        sq;

  logic [47:0] grid_prod;
  logic [32:0] diff;
  logic [31:0] err_clamped;
  logic [16:0] rel_dl;
  logic [48:0] sum_wide;
  logic [63:0] sq_prod;
  logic [64:0] sq_total;
  logic [63:0] sq_new;

  assign period   = timing[15:0];
  assign deadline = timing[31:16];
  assign duration = timing[47:32];

  assign grid_prod = run_count * period;
  assign diff      = {1'b0, vt} - {1'b0, ideal};
  assign rel_dl    = {1'b0, next_release} + {1'b0, deadline};

  // Clamp the exact difference to the signed 32-bit range.
  always_comb begin
    if (diff[32] == diff[31]) begin
      err_clamped = diff[31:0];
    end else if (diff[32]) begin
      err_clamped = 32'h8000_0000;
    end else begin
      err_clamped = 32'h7FFF_FFFF;
    end
  end

  // Saturating running sum of errors.
  assign sum_wide = {err_sum[47], err_sum} + {{17{err[31]}}, err};

  assign sq_prod  = mag * mag;
  assign sq_total = {1'b0, err_sq_sum} + {1'b0, sq};
  assign sq_new   = sq_total[64] ? '1 : sq_total[63:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy         <= 1'b0;
      phase        <= PH_GRID;
      tok_out      <= 1'b0;
      due          <= 1'b0;
      next_release <= '0;
      run_count    <= '0;
      miss_count   <= '0;
      err_sum      <= '0;
      err_sq_sum   <= '0;
    end else begin
      tok_out <= 1'b0;
      if (eval) begin
        due <= (now_eval >= {16'b0, next_release}) && (next_release < horizon);
      end
      if (link_in.tok && !busy) begin
        if (due) begin
          busy  <= 1'b1;
          phase <= PH_GRID;
          vt    <= link_in.vt;
        end else begin
          tok_out <= 1'b1;
          vt_out  <= link_in.vt;
        end
      end else if (busy) begin
        case (phase)
          PH_GRID: begin
            ideal <= grid_prod[31:0];
            done  <= vt + {16'b0, duration};
            phase <= PH_ERR;
          end
          PH_ERR: begin
            err    <= err_clamped;
            missed <= {1'b0, done} > {16'b0, rel_dl};
            phase  <= PH_SUM;
          end
          PH_SUM: begin
            mag <= err[31] ? (~err + 32'd1) : err;
            if (sum_wide[48] != sum_wide[47]) begin
              sum_new <= sum_wide[48] ? {1'b1, 47'b0} : {1'b0, {47{1'b1}}};
            end else begin
              sum_new <= sum_wide[47:0];
            end
            phase <= PH_SQ;
          end
          PH_SQ: begin
            sq    <= sq_prod;
            phase <= PH_COMMIT;
          end
          PH_COMMIT: begin
            if (out_free) begin
              next_release <= next_release + period;
              run_count    <= run_count + 32'd1;
              miss_count   <= miss_count + {31'b0, missed};
              err_sum      <= sum_new;
              err_sq_sum   <= sq_new;
              busy         <= 1'b0;
              due          <= 1'b0;
              tok_out      <= 1'b1;
              vt_out       <= done;
              phase        <= PH_GRID;
            end
          end
          default: begin
            phase <= PH_GRID;
          end
        endcase
      end
    end
  end

  assign link_out.tok = tok_out;
  assign link_out.vt  = vt_out;

  assign rec_valid = busy && (phase == PH_COMMIT);
  assign rec_last  = is_last;

  assign rec.rel_ms          = next_release;
  assign rec.start_ms        = vt;
  assign rec.done_ms         = done;
  assign rec.deadline_missed = missed;
  assign rec.start_error     = err;
  assign rec.run_total       = run_count + 32'd1;
  assign rec.missed_count    = miss_count + {31'b0, missed};
  assign rec.error_sum       = sum_new;
  assign rec.error_sq_sum    = sq_new;

  assign cnt.next_release = next_release;
  assign cnt.run_count    = run_count;
  assign cnt.miss_count   = miss_count;
  assign cnt.err_sum      = err_sum;
  assign cnt.err_sq_sum   = err_sq_sum;

endmodule
